/* design/two_level_vertex_cache_core_macros.svh */
// Assertion macros for the two-level vertex cache core.
// Expects clk and rst_n in the scope of every use.
`ifndef TWO_LEVEL_VERTEX_CACHE_CORE_MACROS_SVH
`define TWO_LEVEL_VERTEX_CACHE_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TLVC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define TLVC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tlvc_pkg.sv */
// Shared types and constants of the two-level vertex cache core.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps
`default_nettype none

package tlvc_pkg;

  // Parameter defaults
  localparam int NUM_THREADS_DEF  = 8;
  localparam int NEAR_ENTRIES_DEF = 32;
  localparam int FAR_ENTRIES_DEF  = 1024;
  localparam int POOL_DEPTH_DEF   = 4096;

  // Fixed field widths
  localparam int VI_W   = 32;
  localparam int TID_W  = 3;
  localparam int OUTC_W = 3;
  localparam int SLOT_W = 12;
  localparam int CNT_W  = 32;

  // Operation codes
  localparam logic OP_BEGIN_DRAW = 1'b0;
  localparam logic OP_LOOKUP     = 1'b1;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUTC_NEAR_HIT  = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_FAR_HIT   = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_MISS      = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_POOL_FULL = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_DRAW_DONE = 3'd4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic              operation;
    logic [TID_W-1:0]  req_thread;
    logic [VI_W-1:0]   vertex_index;
  } in_item_t;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [TID_W-1:0]  owner_thread;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  fetched_count;
    logic [CNT_W-1:0]  shaded_count;
    logic [CNT_W-1:0]  second_hit_count;
    logic [CNT_W-1:0]  eviction_count;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // latch the input transaction
    logic rd_en;       // read near, far and thread memories
    logic rd_from_in;  // read address from the input payload
    logic rem_start;   // start the index remainder units
    logic clr_en;      // one step of the clearing sweep
    logic out_load;    // load the result register
    logic out_draw;    // result is begin-draw done
    logic commit;      // write back the lookup update
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rem_busy;
    logic rem_instant;
    logic clr_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/tlvc_rem.sv */
// Remainder of a vertex index by a constant set size.
// Power-of-two sizes are a mask; others run 8 bits per cycle. Uses tlvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlvc_rem #(
  parameter int DIVISOR = 32,
  localparam int RW = $clog2(DIVISOR)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tlvc_pkg::VI_W-1:0]  value,
  output logic      [RW-1:0]              rem,
  output logic                            busy,
  output logic                            instant
);

  localparam bit IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;
  localparam int BPS     = 8;
  localparam int STEPS   = tlvc_pkg::VI_W / BPS;
  localparam int SCW     = $clog2(STEPS);

  if (IS_POW2) begin : g_pow2
    // Low bits are the remainder
    assign rem     = value[RW-1:0];
    assign busy    = 1'b0;
    assign instant = 1'b1;
  end else begin : g_iter
    localparam logic [RW:0] DIV_C = (RW + 1)'(DIVISOR);

    logic [tlvc_pkg::VI_W-1:0] sh_r, sh_nxt;
    logic [RW-1:0]             r_r, r_nxt;
    logic [SCW-1:0]            cnt_r, cnt_nxt;
    logic                      busy_r, busy_nxt;

    // Restoring remainder, one byte of the index per cycle
    always_comb begin
      logic [RW:0]   acc;
      logic [RW-1:0] rr;
      sh_nxt   = sh_r;
      r_nxt    = r_r;
      cnt_nxt  = cnt_r;
      busy_nxt = busy_r;
      rr       = r_r;
      acc      = '0;
      if (start) begin
        sh_nxt   = value;
        r_nxt    = '0;
        cnt_nxt  = '0;
        busy_nxt = 1'b1;
      end else if (busy_r) begin
        for (int i = 0; i < BPS; i++) begin
          acc = {rr, sh_r[tlvc_pkg::VI_W-1-i]};
          if (acc >= DIV_C) begin
            acc = acc - DIV_C;
          end
          rr = acc[RW-1:0];
        end
        r_nxt   = rr;
        sh_nxt  = sh_r << BPS;
        cnt_nxt = cnt_r + SCW'(1);
        if (cnt_r == SCW'(STEPS - 1)) begin
          busy_nxt = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
      end else begin
        busy_r <= busy_nxt;
      end
      sh_r  <= sh_nxt;
      r_r   <= r_nxt;
      cnt_r <= cnt_nxt;
    end

    assign rem     = r_r;
    assign busy    = busy_r;
    assign instant = 1'b0;
  end

endmodule

`default_nettype wire

/* design/tlvc_dpath.sv */
// Datapath of the vertex cache: near, far and per-thread memories,
// lookup compare, counter update and result register. Uses tlvc_pkg, tlvc_rem.
`timescale 1ns / 1ps
`default_nettype none

module tlvc_dpath #(
  parameter int NUM_THREADS  = tlvc_pkg::NUM_THREADS_DEF,
  parameter int NEAR_ENTRIES = tlvc_pkg::NEAR_ENTRIES_DEF,
  parameter int FAR_ENTRIES  = tlvc_pkg::FAR_ENTRIES_DEF,
  parameter int POOL_DEPTH   = tlvc_pkg::POOL_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tlvc_pkg::in_item_t    in_data,
  input  wire tlvc_pkg::ctrl_cmd_t   cmd,
  output tlvc_pkg::dp_status_t       st,
  output tlvc_pkg::out_item_t        out_data
);

  localparam int TW         = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int NEAR_TOTAL = NUM_THREADS * NEAR_ENTRIES;
  localparam int NAW        = $clog2(NEAR_TOTAL);
  localparam int NRW        = $clog2(NEAR_ENTRIES);
  localparam int FAW        = $clog2(FAR_ENTRIES);
  localparam int SW         = $clog2(POOL_DEPTH);
  localparam int PNW        = $clog2(POOL_DEPTH + 1);
  localparam int SWEEP      = (NEAR_TOTAL > FAR_ENTRIES) ? NEAR_TOTAL : FAR_ENTRIES;
  localparam int CW         = $clog2(SWEEP);
  localparam int VI_W       = tlvc_pkg::VI_W;
  localparam int CNT_W      = tlvc_pkg::CNT_W;

  localparam logic [NAW-1:0] NEAR_MUL = NAW'(NEAR_ENTRIES);

  typedef struct packed {
    logic            valid;
    logic [VI_W-1:0] tag;
    logic [TW-1:0]   owner;
    logic [SW-1:0]   slot;
  } entry_t;

  typedef struct packed {
    logic [PNW-1:0]   pool_next;
    logic [CNT_W-1:0] fetched;
    logic [CNT_W-1:0] shaded;
    logic [CNT_W-1:0] second;
    logic [CNT_W-1:0] evict;
  } thr_rec_t;

  localparam entry_t ENTRY_CLR = '{valid: 1'b0, tag: '1, owner: '0, slot: '0};

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == tlvc_pkg::CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // Thread id modulo the thread count by repeated subtraction
  function automatic logic [TW-1:0] thread_wrap(input logic [tlvc_pkg::TID_W-1:0] id);
    logic [6:0] v;
    v = 7'(id);
    for (int i = 0; i < 7; i++) begin
      if (v >= 7'(NUM_THREADS)) begin
        v = v - 7'(NUM_THREADS);
      end
    end
    return TW'(v);
  endfunction

  // Memories and registered read data
  entry_t   near_mem [NEAR_TOTAL];
  entry_t   far_mem  [FAR_ENTRIES];
  thr_rec_t thr_mem  [NUM_THREADS];

  entry_t   near_q_r, far_q_r;
  thr_rec_t thr_q_r;

  logic [TW-1:0]   t_in, t_sel, t_r;
  logic [VI_W-1:0] vi_r, rem_value;
  logic [NRW-1:0]  nrem;
  logic [FAW-1:0]  frem;
  logic            nrem_busy, nrem_inst, frem_busy, frem_inst;
  logic [NAW-1:0]  near_rd_addr, near_addr_r;
  logic [FAW-1:0]  far_addr_r;
  logic [TW-1:0]   thr_addr_r;
  logic [CW-1:0]   clr_cnt_r;
  logic            clr_last;

  // Latched transaction
  assign t_in = thread_wrap(in_data.req_thread);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r  <= t_in;
      vi_r <= in_data.vertex_index;
    end
  end

  // Set index remainders
  assign rem_value = cmd.rd_from_in ? in_data.vertex_index : vi_r;

  tlvc_rem #(.DIVISOR(NEAR_ENTRIES)) u_near_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.rem_start),
    .value   (rem_value),
    .rem     (nrem),
    .busy    (nrem_busy),
    .instant (nrem_inst)
  );

  tlvc_rem #(.DIVISOR(FAR_ENTRIES)) u_far_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.rem_start),
    .value   (rem_value),
    .rem     (frem),
    .busy    (frem_busy),
    .instant (frem_inst)
  );

  assign t_sel        = cmd.rd_from_in ? t_in : t_r;
  assign near_rd_addr = NAW'(t_sel) * NEAR_MUL + NAW'(nrem);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      near_addr_r <= near_rd_addr;
      far_addr_r  <= frem;
      thr_addr_r  <= t_sel;
    end
  end

  // Clearing sweep counter
  assign clr_last = clr_cnt_r == CW'(SWEEP - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_last ? '0 : clr_cnt_r + CW'(1);
    end
  end

  assign st.rem_busy    = nrem_busy | frem_busy;
  assign st.rem_instant = nrem_inst & frem_inst;
  assign st.clr_last    = clr_last;

  // Lookup decision on the registered read data
  logic                          near_hit, far_hit, pool_full, near_upd, far_upd;
  logic [tlvc_pkg::OUTC_W-1:0]   oc;
  logic [TW-1:0]                 owner;
  logic [SW-1:0]                 slot;
  thr_rec_t                      thr_new;

  always_comb begin
    near_hit  = near_q_r.valid && (near_q_r.tag == vi_r);
    far_hit   = far_q_r.valid && (far_q_r.tag == vi_r);
    pool_full = thr_q_r.pool_next >= PNW'(POOL_DEPTH);
    near_upd  = 1'b0;
    far_upd   = 1'b0;
    owner     = t_r;
    slot      = '0;
    thr_new   = thr_q_r;
    thr_new.fetched = sat_inc(thr_q_r.fetched);
    if (near_hit) begin
      oc    = tlvc_pkg::OUTC_NEAR_HIT;
      owner = near_q_r.owner;
      slot  = near_q_r.slot;
    end else if (far_hit) begin
      oc             = tlvc_pkg::OUTC_FAR_HIT;
      owner          = far_q_r.owner;
      slot           = far_q_r.slot;
      near_upd       = 1'b1;
      thr_new.second = sat_inc(thr_q_r.second);
    end else if (pool_full) begin
      oc = tlvc_pkg::OUTC_POOL_FULL;
    end else begin
      oc                = tlvc_pkg::OUTC_MISS;
      slot              = thr_q_r.pool_next[SW-1:0];
      near_upd          = 1'b1;
      far_upd           = 1'b1;
      thr_new.pool_next = thr_q_r.pool_next + PNW'(1);
      thr_new.shaded    = sat_inc(thr_q_r.shaded);
      if (far_q_r.valid) begin
        thr_new.evict = sat_inc(thr_q_r.evict);
      end
    end
  end

  // Write ports: sweep or lookup write-back
  entry_t         fill;
  logic           near_we, far_we, thr_we;
  logic [NAW-1:0] near_wa;
  logic [FAW-1:0] far_wa;
  logic [TW-1:0]  thr_wa;
  entry_t         near_wd, far_wd;
  thr_rec_t       thr_wd;

  assign fill = '{valid: 1'b1, tag: vi_r, owner: owner, slot: slot};

  always_comb begin
    if (cmd.clr_en) begin
      near_we = {1'b0, clr_cnt_r} < (CW + 1)'(NEAR_TOTAL);
      far_we  = {1'b0, clr_cnt_r} < (CW + 1)'(FAR_ENTRIES);
      thr_we  = {1'b0, clr_cnt_r} < (CW + 1)'(NUM_THREADS);
      near_wa = clr_cnt_r[NAW-1:0];
      far_wa  = clr_cnt_r[FAW-1:0];
      thr_wa  = TW'(clr_cnt_r);
      near_wd = ENTRY_CLR;
      far_wd  = ENTRY_CLR;
      thr_wd  = '0;
    end else begin
      near_we = cmd.commit && near_upd;
      far_we  = cmd.commit && far_upd;
      thr_we  = cmd.commit;
      near_wa = near_addr_r;
      far_wa  = far_addr_r;
      thr_wa  = thr_addr_r;
      near_wd = fill;
      far_wd  = fill;
      thr_wd  = thr_new;
    end
  end

  always_ff @(posedge clk) begin
    if (near_we) begin
      near_mem[near_wa] <= near_wd;
    end
    if (cmd.rd_en) begin
      near_q_r <= near_mem[near_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (far_we) begin
      far_mem[far_wa] <= far_wd;
    end
    if (cmd.rd_en) begin
      far_q_r <= far_mem[frem];
    end
  end

  always_ff @(posedge clk) begin
    if (thr_we) begin
      thr_mem[thr_wa] <= thr_wd;
    end
    if (cmd.rd_en) begin
      thr_q_r <= thr_mem[t_sel];
    end
  end

  // Result register
  tlvc_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_draw) begin
        out_r.outcome          <= tlvc_pkg::OUTC_DRAW_DONE;
        out_r.owner_thread     <= tlvc_pkg::TID_W'(t_r);
        out_r.slot             <= '0;
        out_r.fetched_count    <= '0;
        out_r.shaded_count     <= '0;
        out_r.second_hit_count <= '0;
        out_r.eviction_count   <= '0;
      end else begin
        out_r.outcome          <= oc;
        out_r.owner_thread     <= tlvc_pkg::TID_W'(owner);
        out_r.slot             <= tlvc_pkg::SLOT_W'(slot);
        out_r.fetched_count    <= thr_new.fetched;
        out_r.shaded_count     <= thr_new.shaded;
        out_r.second_hit_count <= thr_new.second;
        out_r.eviction_count   <= thr_new.evict;
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

/* design/tlvc_ctrl.sv */
// Controller of the vertex cache: clearing sweep, lookup sequencing
// and result valid. Uses tlvc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlvc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_operation,
  output logic                      in_ready,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  input  wire tlvc_pkg::dp_status_t st,
  output tlvc_pkg::ctrl_cmd_t       cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       draw_r, draw_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = state_r == S_IDLE;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    draw_nxt      = draw_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_last) begin
          state_nxt = draw_r ? S_CMP : S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_from_in = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_operation == tlvc_pkg::OP_BEGIN_DRAW) begin
            draw_nxt  = 1'b1;
            state_nxt = S_CLEAR;
          end else begin
            draw_nxt = 1'b0;
            if (st.rem_instant) begin
              state_nxt = S_CMP;
            end else begin
              cmd.rem_start = 1'b1;
              state_nxt     = S_MOD;
            end
          end
        end
      end
      S_MOD: begin
        if (!st.rem_busy) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_draw  = draw_r;
          cmd.commit    = !draw_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      draw_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      draw_r      <= draw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* design/two_level_vertex_cache_core.sv */
// Two-level post-transform vertex cache, top level.
// Input channel in_valid/in_ready/in_data: begin draw or one vertex lookup.
// Result channel out_valid/out_ready/out_data: one result per transaction.
// Each thread owns a direct-mapped near level; all share a far level.
// Lookup steps: with power-of-two set sizes the memories are read at
// acceptance, then a compare and write-back step loads the result.
// Otherwise the set index comes from a remainder unit working 8 bits per
// cycle; a lookup runs acceptance, remainder, memory read, then compare
// and write-back. No new lookup is taken before the compare step is done.
// Reset and begin draw run a clearing sweep over the memories of
// max(NUM_THREADS*NEAR_ENTRIES, FAR_ENTRIES) addresses (1024 by default),
// during which no input is taken; begin draw answers after the sweep.
// The result register lets the next input be taken while a result waits;
// a stalled receiver holds the following result in the compare step.
// Depends on tlvc_pkg, tlvc_ctrl, tlvc_dpath and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "two_level_vertex_cache_core_macros.svh"

module two_level_vertex_cache_core #(
  parameter int NUM_THREADS  = tlvc_pkg::NUM_THREADS_DEF,
  parameter int NEAR_ENTRIES = tlvc_pkg::NEAR_ENTRIES_DEF,
  parameter int FAR_ENTRIES  = tlvc_pkg::FAR_ENTRIES_DEF,
  parameter int POOL_DEPTH   = tlvc_pkg::POOL_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tlvc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tlvc_pkg::out_item_t      out_data
);

  tlvc_pkg::ctrl_cmd_t  cmd;
  tlvc_pkg::dp_status_t st;

  tlvc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_data.operation),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .st           (st),
    .cmd          (cmd)
  );

  tlvc_dpath #(
    .NUM_THREADS  (NUM_THREADS),
    .NEAR_ENTRIES (NEAR_ENTRIES),
    .FAR_ENTRIES  (FAR_ENTRIES),
    .POOL_DEPTH   (POOL_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

  // Checks
  `TLVC_ASSERT_IMP(a_no_accept_in_sweep, cmd.clr_en, !in_ready, "transaction taken during sweep")
  `TLVC_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `TLVC_ASSERT_NXT(a_one_item_in_flight, in_valid && in_ready, !in_ready, "second item taken early")
  `TLVC_ASSERT_IMP(a_pool_full_slot, out_valid && out_data.outcome == tlvc_pkg::OUTC_POOL_FULL, out_data.slot == '0, "pool full with nonzero slot")

endmodule

`default_nettype wire
